// ===== src/pwc_pkg.sv =====
// Shared types, codes and constants of the soil-moisture pump controller.
package pwc_pkg;

    // Averaging group size (1..16).
    localparam int AVG_SAMPLES = 10;

    // Field widths
    localparam int REQ_W     = 2;
    localparam int ADC_W     = 12;
    localparam int CMD_W     = 3;
    localparam int EV_W      = 3;
    localparam int PCT_W     = 7;
    localparam int CNT8_W    = 8;
    localparam int SUM_W     = 16;
    localparam int SCNT_W    = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Config port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    // Divider: dividend up to 4095 * 100, divisor up to 4095
    localparam int DIV_W      = 19;
    localparam int DVS_W      = 12;
    localparam int DIV_STEPS  = DIV_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Average by reciprocal: (sum * AVG_RECIP) >> AVG_SH is exact for any 16-bit sum
    localparam int AVG_SH      = SUM_W + $clog2(AVG_SAMPLES);
    localparam int AVG_RECIP_W = SUM_W + 1;
    localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'(((64'd1 << AVG_SH) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

    localparam int PCT_FULL   = 100;
    localparam int CNT_SAT    = 255;

    // Register reset values
    localparam logic [PCT_W-1:0]  RST_DRY_THR    = 7'd30;
    localparam logic [PCT_W-1:0]  RST_OFF_MARGIN = 7'd5;
    localparam logic [CNT8_W-1:0] RST_MAX_RUN    = 8'd10;
    localparam logic [CNT8_W-1:0] RST_COOL_TICKS = 8'd30;
    localparam logic [ADC_W-1:0]  RST_RAW_DRY    = 12'd2700;
    localparam logic [ADC_W-1:0]  RST_RAW_WET    = 12'd1500;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DRY_THR    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFF_MARGIN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RUN    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COOL_TICKS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAW_DRY    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAW_WET    = 3'd5;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADC  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CMD  = 2'd2;

    // Operator commands
    localparam logic [CMD_W-1:0] CMD_HELP       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STREAM_ON  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STREAM_OFF = 3'd3;
    localparam logic [CMD_W-1:0] CMD_AUTO       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MANUAL     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ON         = 3'd6;
    localparam logic [CMD_W-1:0] CMD_OFF        = 3'd7;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EV_W-1:0] EV_AUTO_ON    = 3'd1;
    localparam logic [EV_W-1:0] EV_RECOVERED  = 3'd2;
    localparam logic [EV_W-1:0] EV_SAFETY_OFF = 3'd3;
    localparam logic [EV_W-1:0] EV_COOL_DONE  = 3'd4;
    localparam logic [EV_W-1:0] EV_BLOCKED    = 3'd5;
    localparam logic [EV_W-1:0] EV_MANUAL_ON  = 3'd6;
    localparam logic [EV_W-1:0] EV_MANUAL_OFF = 3'd7;

    // Controller -> datapath
    typedef struct packed {
        logic accept;     // take the input item
        logic avg_latch;  // store averaged raw reading
        logic pct_start;  // start scaled diff / range
        logic pct_zero;   // store percent 0 (bad calibration or too dry)
        logic pct_latch;  // store clamped percent
        logic commit;     // update state and load the result item
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic need_avg;   // incoming conversion closes a group
        logic div_done;
        logic pct_zero;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/pwc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pwc_div import pwc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W:0]       r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0] w_rem_sh;
    logic           w_ge;

    assign w_rem_sh = {r_rem[DVS_W-1:0], r_quo[DIV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Dividend shifts out of the top of r_quo as quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/pwc_dp.sv =====
// Datapath: config registers, controller state, averaging, scaling and result register.
module pwc_dp import pwc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [REQ_W-1:0]      i_in_user,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    // Config
    logic [PCT_W-1:0]  r_dry_thr;
    logic [PCT_W-1:0]  r_off_margin;
    logic [CNT8_W-1:0] r_max_run;
    logic [CNT8_W-1:0] r_cool_ticks;
    logic [ADC_W-1:0]  r_raw_dry;
    logic [ADC_W-1:0]  r_raw_wet;

    // Latched item
    logic [REQ_W-1:0] r_req;
    logic [CMD_W-1:0] r_cmd;
    logic             r_grp_done;

    // Controller state
    logic              r_pump, r_cool, r_auto, r_stream;
    logic [CNT8_W-1:0] r_run_cnt, r_cool_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic [SCNT_W-1:0] r_cnt;
    logic [ADC_W-1:0]  r_latest_raw;
    logic [PCT_W-1:0]  r_latest_pct;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Input fields
    logic [ADC_W-1:0] w_adc;
    logic [CMD_W-1:0] w_cmd_code;
    assign w_adc      = i_in_data[ADC_W-1:0];
    assign w_cmd_code = i_in_data[ADC_W +: CMD_W];

    logic [SUM_W-1:0]  w_sum_next;
    logic [SCNT_W:0]   w_cnt_next;
    logic              w_grp_done;
    assign w_sum_next = r_sum + SUM_W'(w_adc);
    assign w_cnt_next = {1'b0, r_cnt} + 1'b1;
    assign w_grp_done = (i_in_user == REQ_ADC) && (w_cnt_next >= (SCNT_W+1)'(AVG_SAMPLES));

    // Group average: reciprocal multiply, low 12 bits of the quotient kept
    logic [AVG_PROD_W-1:0] w_avg_prod;
    logic [ADC_W-1:0]      w_avg;
    assign w_avg_prod = AVG_PROD_W'(r_sum) * AVG_PROD_W'(AVG_RECIP);
    assign w_avg      = w_avg_prod[AVG_SH +: ADC_W];

    // Divider and percent scaling
    logic             w_div_start;
    logic [DIV_W-1:0] w_dividend;
    logic [DVS_W-1:0] w_divisor;
    logic             w_div_done;
    logic [DIV_W-1:0] w_quo;
    logic [ADC_W-1:0] w_diff;
    logic [DIV_W-1:0] w_prod;
    logic             w_pct_zero;

    assign w_diff     = r_raw_dry - r_latest_raw;
    assign w_prod     = DIV_W'(w_diff) * DIV_W'(PCT_FULL);
    assign w_pct_zero = (r_raw_dry <= r_raw_wet) || (r_latest_raw >= r_raw_dry);

    assign w_div_start = i_cmd.pct_start;
    assign w_dividend  = w_prod;
    assign w_divisor   = r_raw_dry - r_raw_wet;

    pwc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    logic [PCT_W-1:0] w_pct_clamped;
    assign w_pct_clamped = (w_quo > DIV_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : w_quo[PCT_W-1:0];

    // Item update, evaluated in model order
    logic              n_pump, n_cool, n_auto, n_stream;
    logic [CNT8_W-1:0] n_run_cnt, n_cool_cnt;
    logic [EV_W-1:0]   n_event;
    logic              n_report;
    logic [PCT_W:0]    w_off_level;

    assign w_off_level = {1'b0, r_dry_thr} + {1'b0, r_off_margin};

    always_comb begin
        n_pump     = r_pump;
        n_cool     = r_cool;
        n_auto     = r_auto;
        n_stream   = r_stream;
        n_run_cnt  = r_run_cnt;
        n_cool_cnt = r_cool_cnt;
        n_event    = EV_NONE;
        n_report   = 1'b0;
        case (r_req)
            REQ_TICK: begin
                if (n_pump) begin
                    if (n_run_cnt != CNT8_W'(CNT_SAT)) begin
                        n_run_cnt = n_run_cnt + 1'b1;
                    end
                    if (n_run_cnt >= r_max_run) begin
                        n_pump     = 1'b0;
                        n_run_cnt  = '0;
                        n_cool     = 1'b1;
                        n_cool_cnt = '0;
                        n_event    = EV_SAFETY_OFF;
                    end
                end
                // A safety stop above feeds straight into this cooldown step.
                if (n_cool) begin
                    if (n_cool_cnt != CNT8_W'(CNT_SAT)) begin
                        n_cool_cnt = n_cool_cnt + 1'b1;
                    end
                    if (n_cool_cnt >= r_cool_ticks) begin
                        n_cool     = 1'b0;
                        n_cool_cnt = '0;
                        if (n_event == EV_NONE) begin
                            n_event = EV_COOL_DONE;
                        end
                    end
                end
            end
            REQ_ADC: begin
                if (r_grp_done) begin
                    if (n_auto && !n_pump && !n_cool && (r_latest_pct < r_dry_thr)) begin
                        n_pump    = 1'b1;
                        n_run_cnt = '0;
                        n_event   = EV_AUTO_ON;
                    end
                    if (n_pump && ({1'b0, r_latest_pct} >= w_off_level)) begin
                        n_pump     = 1'b0;
                        n_run_cnt  = '0;
                        n_cool     = 1'b1;
                        n_cool_cnt = '0;
                        n_event    = EV_RECOVERED;
                    end
                    n_report = r_stream;
                end
            end
            REQ_CMD: begin
                case (r_cmd)
                    CMD_HELP:       n_report = 1'b0;
                    CMD_STATUS:     n_report = 1'b1;
                    CMD_STREAM_ON:  n_stream = 1'b1;
                    CMD_STREAM_OFF: n_stream = 1'b0;
                    CMD_AUTO: begin
                        n_auto   = 1'b1;
                        n_report = 1'b1;
                    end
                    CMD_MANUAL: begin
                        n_auto    = 1'b0;
                        n_pump    = 1'b0;
                        n_run_cnt = '0;
                        n_report  = 1'b1;
                    end
                    CMD_ON: begin
                        n_auto = 1'b0;
                        if (n_cool) begin
                            n_event = EV_BLOCKED;
                        end else begin
                            n_pump    = 1'b1;
                            n_run_cnt = '0;
                            n_event   = EV_MANUAL_ON;
                            n_report  = 1'b1;
                        end
                    end
                    CMD_OFF: begin
                        n_pump    = 1'b0;
                        n_run_cnt = '0;
                        n_event   = EV_MANUAL_OFF;
                        n_report  = 1'b1;
                    end
                    default: n_report = 1'b0;
                endcase
            end
            default: n_report = 1'b0;
        endcase
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry_thr    <= RST_DRY_THR;
            r_off_margin <= RST_OFF_MARGIN;
            r_max_run    <= RST_MAX_RUN;
            r_cool_ticks <= RST_COOL_TICKS;
            r_raw_dry    <= RST_RAW_DRY;
            r_raw_wet    <= RST_RAW_WET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DRY_THR:    r_dry_thr    <= i_cfg_wdata[PCT_W-1:0];
                CFG_OFF_MARGIN: r_off_margin <= i_cfg_wdata[PCT_W-1:0];
                CFG_MAX_RUN:    r_max_run    <= i_cfg_wdata[CNT8_W-1:0];
                CFG_COOL_TICKS: r_cool_ticks <= i_cfg_wdata[CNT8_W-1:0];
                CFG_RAW_DRY:    r_raw_dry    <= i_cfg_wdata[ADC_W-1:0];
                CFG_RAW_WET:    r_raw_wet    <= i_cfg_wdata[ADC_W-1:0];
                default: ;
            endcase
        end
    end

    // Item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req      <= i_in_user;
            r_cmd      <= w_cmd_code;
            r_grp_done <= w_grp_done;
        end
    end

    // State
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump       <= 1'b0;
            r_cool       <= 1'b0;
            r_auto       <= 1'b0;
            r_stream     <= 1'b0;
            r_run_cnt    <= '0;
            r_cool_cnt   <= '0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_latest_raw <= '0;
            r_latest_pct <= '0;
        end else begin
            if (i_cmd.accept && (i_in_user == REQ_ADC)) begin
                r_sum <= w_sum_next;
                r_cnt <= w_grp_done ? '0 : w_cnt_next[SCNT_W-1:0];
            end
            if (i_cmd.avg_latch) begin
                r_latest_raw <= w_avg;
                r_sum        <= '0;
            end
            if (i_cmd.pct_zero) begin
                r_latest_pct <= '0;
            end
            if (i_cmd.pct_latch) begin
                r_latest_pct <= w_pct_clamped;
            end
            if (i_cmd.commit) begin
                r_pump     <= n_pump;
                r_cool     <= n_cool;
                r_auto     <= n_auto;
                r_stream   <= n_stream;
                r_run_cnt  <= n_run_cnt;
                r_cool_cnt <= n_cool_cnt;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {6'b0, n_report, r_latest_pct, r_latest_raw, n_event,
                           n_cool, n_auto, n_pump};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.need_avg = w_grp_done;
    assign o_sts.div_done = w_div_done;
    assign o_sts.pct_zero = w_pct_zero;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

// ===== src/pwc_ctrl.sv =====
// Controller state machine: sequences accept, averaging, scaling and commit.
module pwc_ctrl import pwc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_AVG      = 5'b00010,
        S_SCALE    = 5'b00100,
        S_PCT_WAIT = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.need_avg ? S_AVG : S_DONE;
                end
            end
            S_AVG: begin
                o_cmd.avg_latch = 1'b1;
                n_state         = S_SCALE;
            end
            S_SCALE: begin
                if (i_sts.pct_zero) begin
                    o_cmd.pct_zero = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.pct_start = 1'b1;
                    n_state         = S_PCT_WAIT;
                end
            end
            S_PCT_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.pct_latch = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== src/pump_watering_controller.sv =====
// Top level of the soil-moisture pump controller.
//
//  channel   dir  signals                       contents
//  --------  ---  ----------------------------  ---------------------------------
//  s_axis    in   tvalid/tready/tdata/tuser     request item (tick, ADC, command)
//  m_axis    out  tvalid/tready/tdata           one result item per request
//  cfg       in   i_cfg_we/i_cfg_addr/i_cfg_wdata  calibration and limit registers
//
// Ticks, commands and partial conversions go through accept and commit. A
// conversion that closes an averaging group also passes S_AVG, S_SCALE and
// S_PCT_WAIT: the average is a reciprocal multiply, then the 19-step restoring
// divider forms the percentage; the divider is skipped when the percent is forced 0.
// One item is in flight at a time; the result register lets a finished item wait
// on m_axis_tready while the next item is accepted.
// Reset (synchronous, active low) clears all control state and loads the
// register defaults; no clearing pass is needed.
module pump_watering_controller import pwc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Config
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Request items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [11:0] adc_value, [14:12] cmd_code, [15] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]      s_axis_tuser,
    // Result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] pump_on, [1] auto_enabled, [2] in_cooldown, [5:3] event_res,
    // [17:6] average_raw, [24:18] moisture_percent, [25] report, [31:26] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pwc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the soil-moisture pump controller.
`timescale 1ns / 1ps

module tb;
    import pwc_pkg::*;

    // tuser code that the block must ignore, and a register index with no register
    localparam logic [REQ_W-1:0]      REQ_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE  = 3'd7;

    localparam int N_PHASES    = 10;
    localparam int MAX_IDLE    = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 100;

    // Request as it travels on s_axis: tuser on top, tdata[14:0] below
    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [CMD_W-1:0] cmd;
        logic [ADC_W-1:0] adc;
    } t_req_item;

    // Result fields in m_axis_tdata[25:0] order (MSB first)
    typedef struct packed {
        logic             report;
        logic [PCT_W-1:0] pct;
        logic [ADC_W-1:0] avg;
        logic [EV_W-1:0]  ev;
        logic             cooling;
        logic             auto_on;
        logic             pump;
    } t_status;

    // ---------------------------------------------------------------------
    // DUT signals, inputs known from time zero
    // ---------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [REQ_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    pump_watering_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Controller prediction: own copy of registers and state
    // ---------------------------------------------------------------------
    logic [PCT_W-1:0]  thr_pct    = RST_DRY_THR;
    logic [PCT_W-1:0]  margin_pct = RST_OFF_MARGIN;
    logic [CNT8_W-1:0] max_run    = RST_MAX_RUN;
    logic [CNT8_W-1:0] cool_len   = RST_COOL_TICKS;
    logic [ADC_W-1:0]  raw_dry    = RST_RAW_DRY;
    logic [ADC_W-1:0]  raw_wet    = RST_RAW_WET;

    logic              pump_run   = 1'b0;
    logic              cooling    = 1'b0;
    logic              auto_mode  = 1'b0;
    logic              streaming  = 1'b0;
    logic [CNT8_W-1:0] run_secs   = '0;
    logic [CNT8_W-1:0] cool_secs  = '0;
    logic [SUM_W-1:0]  adc_sum    = '0;
    int unsigned       adc_count  = 0;
    logic [ADC_W-1:0]  avg_raw    = '0;
    logic [PCT_W-1:0]  moist_pct  = '0;

    // Raw reading to clamped percent; a non-positive calibration span or a raw at or above raw_dry reads as 0
    function automatic logic [PCT_W-1:0] moisture_of(input logic [ADC_W-1:0] raw);
        int unsigned span;
        int unsigned p;
        if (raw_dry <= raw_wet || raw >= raw_dry)
            return '0;
        span = raw_dry - raw_wet;
        p = ((raw_dry - raw) * PCT_FULL) / span;
        return (p > PCT_FULL) ? PCT_W'(PCT_FULL) : PCT_W'(p);
    endfunction

    task automatic step_controller(input t_req_item it, output t_status st);
        logic [EV_W-1:0] ev;
        logic            rep;
        int unsigned     stop_level;
        ev  = EV_NONE;
        rep = 1'b0;
        case (it.kind)
            REQ_TICK: begin
                if (pump_run) begin
                    if (run_secs < CNT_SAT)
                        run_secs++;
                    if (run_secs >= max_run) begin
                        // safety stop, cooldown starts and may end on this same tick
                        pump_run  = 1'b0;
                        run_secs  = '0;
                        cooling   = 1'b1;
                        cool_secs = '0;
                        ev        = EV_SAFETY_OFF;
                    end
                end
                if (cooling) begin
                    if (cool_secs < CNT_SAT)
                        cool_secs++;
                    if (cool_secs >= cool_len) begin
                        cooling   = 1'b0;
                        cool_secs = '0;
                        if (ev == EV_NONE)
                            ev = EV_COOL_DONE;
                    end
                end
            end
            REQ_ADC: begin
                adc_sum = adc_sum + it.adc;
                adc_count++;
                if (adc_count >= AVG_SAMPLES) begin
                    avg_raw   = ADC_W'(adc_sum / AVG_SAMPLES);
                    adc_sum   = '0;
                    adc_count = 0;
                    moist_pct = moisture_of(avg_raw);
                    if (auto_mode && !pump_run && !cooling && moist_pct < thr_pct) begin
                        pump_run = 1'b1;
                        run_secs = '0;
                        ev       = EV_AUTO_ON;
                    end
                    // stop level can exceed 7 bits, keep it wide
                    stop_level = thr_pct + margin_pct;
                    if (pump_run && moist_pct >= stop_level) begin
                        pump_run  = 1'b0;
                        run_secs  = '0;
                        cooling   = 1'b1;
                        cool_secs = '0;
                        ev        = EV_RECOVERED;
                    end
                    rep = streaming;
                end
            end
            REQ_CMD: begin
                case (it.cmd)
                    CMD_HELP:       ;
                    CMD_STATUS:     rep = 1'b1;
                    CMD_STREAM_ON:  streaming = 1'b1;
                    CMD_STREAM_OFF: streaming = 1'b0;
                    CMD_AUTO: begin
                        auto_mode = 1'b1;
                        rep       = 1'b1;
                    end
                    CMD_MANUAL: begin
                        // stops the pump, no cooldown
                        auto_mode = 1'b0;
                        pump_run  = 1'b0;
                        run_secs  = '0;
                        rep       = 1'b1;
                    end
                    CMD_ON: begin
                        auto_mode = 1'b0;
                        if (cooling) begin
                            ev = EV_BLOCKED;
                        end else begin
                            pump_run = 1'b1;
                            run_secs = '0;
                            ev       = EV_MANUAL_ON;
                            rep      = 1'b1;
                        end
                    end
                    CMD_OFF: begin
                        pump_run = 1'b0;
                        run_secs = '0;
                        ev       = EV_MANUAL_OFF;
                        rep      = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;  // unused request kind: no change, empty event
        endcase
        st.pump    = pump_run;
        st.auto_on = auto_mode;
        st.cooling = cooling;
        st.ev      = ev;
        st.avg     = avg_raw;
        st.pct     = moist_pct;
        st.report  = rep;
    endtask

    // ---------------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------------
    t_req_item   req_queue[$];       // items waiting for the driver
    t_status     pending_status[$];  // predicted results, oldest first
    int          mismatches = 0;

    logic        calm       = 1'b0;  // phase with no idling on either side
    int unsigned tick_share = 35;    // percent of items that are ticks
    logic        quiet_cmds = 1'b0;  // commands that keep a running pump running
    int unsigned group_left = 0;     // conversions left in the current averaging group
    int          group_target;
    logic        group_wild;

    task automatic push_req(input logic [REQ_W-1:0] kind, input logic [CMD_W-1:0] cmd,
                            input logic [ADC_W-1:0] adc);
        t_req_item it;
        it.kind = kind;
        it.cmd  = cmd;
        it.adc  = adc;
        req_queue.push_back(it);
    endtask

    // Conversions come in groups aimed at one moisture level, so that averages spread
    // over the whole percent range and the raw extremes; some groups are pure noise.
    task automatic make_req(output t_req_item it);
        int unsigned roll;
        int unsigned pct;
        int          span;
        int          raw;
        it.kind = REQ_CMD;
        it.cmd  = CMD_W'($urandom);
        it.adc  = ADC_W'($urandom);
        roll    = $urandom_range(0, 99);
        if (roll < 3) begin
            it.kind = REQ_UNUSED;
        end else if (roll < 3 + tick_share) begin
            it.kind = REQ_TICK;
        end else if ($urandom_range(0, 9) < 6) begin
            it.kind = REQ_ADC;
            if (group_left == 0) begin
                group_left = AVG_SAMPLES;
                group_wild = ($urandom_range(0, 5) == 0);
                span = int'(raw_dry) - int'(raw_wet);
                pct  = $urandom_range(0, 110);
                if (span > 0)
                    group_target = int'(raw_dry) - int'(pct) * span / PCT_FULL;
                else
                    group_target = $urandom_range(0, 4095);
                case ($urandom_range(0, 9))
                    0: group_target = 0;
                    1: group_target = 4095;
                    default: ;
                endcase
            end
            group_left--;
            if (!group_wild) begin
                raw = group_target + int'($urandom_range(0, 40)) - 20;
                if (raw < 0)
                    it.adc = '0;
                else if (raw > 4095)
                    it.adc = '1;
                else
                    it.adc = ADC_W'(raw);
            end
        end else if (quiet_cmds) begin
            case ($urandom_range(0, 3))
                0: it.cmd = CMD_ON;
                1: it.cmd = CMD_STATUS;
                2: it.cmd = CMD_AUTO;
                default: it.cmd = CMD_HELP;
            endcase
        end else if ($urandom_range(0, 3) == 0) begin
            it.cmd = CMD_AUTO;  // keep auto mode on often enough to see auto starts
        end
    endtask

    // Config write: one register per clock, predictor copy follows at once
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= CFG_DATA_W'(val);
        case (idx)
            CFG_DRY_THR:    thr_pct    = PCT_W'(val);
            CFG_OFF_MARGIN: margin_pct = PCT_W'(val);
            CFG_MAX_RUN:    max_run    = CNT8_W'(val);
            CFG_COOL_TICKS: cool_len   = CNT8_W'(val);
            CFG_RAW_DRY:    raw_dry    = ADC_W'(val);
            CFG_RAW_WET:    raw_wet    = ADC_W'(val);
            default: ;
        endcase
    endtask

    task automatic write_all(input int unsigned thr, input int unsigned margin,
                             input int unsigned run, input int unsigned cool,
                             input int unsigned dry, input int unsigned wet);
        write_reg(CFG_DRY_THR, thr);
        write_reg(CFG_OFF_MARGIN, margin);
        write_reg(CFG_MAX_RUN, run);
        write_reg(CFG_COOL_TICKS, cool);
        write_reg(CFG_RAW_DRY, dry);
        write_reg(CFG_RAW_WET, wet);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Block is idle once the driver is drained and every result has come back
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (req_queue.size() != 0 || s_axis_tvalid || pending_status.size() != 0);
    endtask

    // ---------------------------------------------------------------------
    // Driver: s_axis side, predicts on every accepted item
    // ---------------------------------------------------------------------
    int unsigned send_idle = 0;
    t_req_item   drv_item;
    t_status     drv_status;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_idle     <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                step_controller(t_req_item'({s_axis_tuser, s_axis_tdata[14:0]}), drv_status);
                pending_status.push_back(drv_status);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_idle != 0) begin
                    send_idle     <= send_idle - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (req_queue.size() != 0) begin
                    drv_item       = req_queue.pop_front();
                    s_axis_tuser  <= drv_item.kind;
                    s_axis_tdata  <= {1'b0, drv_item.cmd, drv_item.adc};
                    s_axis_tvalid <= 1'b1;
                    // gap that follows this item once it is taken
                    send_idle     <= calm ? 0 : $urandom_range(0, MAX_IDLE);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: m_axis side with random back-pressure, in-order compare
    // ---------------------------------------------------------------------
    int unsigned recv_idle = 0;
    int unsigned mon_stall;
    t_status     mon_got;
    t_status     mon_want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_idle     <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            mon_got = t_status'(m_axis_tdata[25:0]);
            if (pending_status.size() == 0) begin
                $display("%0t: result %h with no request outstanding", $time, m_axis_tdata);
                mismatches++;
            end else begin
                mon_want = pending_status.pop_front();
                if (mon_got !== mon_want) begin
                    $display({"%0t: mismatch: expected pump %0b auto %0b cool %0b event %0d ",
                              "avg %0d pct %0d report %0b; actual pump %0b auto %0b cool %0b ",
                              "event %0d avg %0d pct %0d report %0b"}, $time,
                             mon_want.pump, mon_want.auto_on, mon_want.cooling, mon_want.ev,
                             mon_want.avg, mon_want.pct, mon_want.report,
                             mon_got.pump, mon_got.auto_on, mon_got.cooling, mon_got.ev,
                             mon_got.avg, mon_got.pct, mon_got.report);
                    mismatches++;
                end
            end
            mon_stall      = calm ? 0 : $urandom_range(0, MAX_IDLE);
            recv_idle     <= mon_stall;
            m_axis_tready <= (mon_stall == 0);
        end else if (recv_idle != 0) begin
            recv_idle     <= recv_idle - 1;
            m_axis_tready <= (recv_idle == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------------
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    int          ph;
    int          n;
    int unsigned phase_items;
    t_req_item   gen_item;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short timers, full-scale calibration, a harmless spare write
        write_reg(CFG_SPARE, 12'hFFF);
        write_all(30, 5, 2, 3, 4095, 0);
        push_req(REQ_CMD, CMD_HELP, '0);
        push_req(REQ_CMD, CMD_STATUS, '1);
        push_req(REQ_CMD, CMD_STREAM_ON, '0);
        push_req(REQ_CMD, CMD_AUTO, '0);
        // nine partial conversions, the tenth closes the group: bone dry, auto start
        for (n = 0; n < AVG_SAMPLES; n++)
            push_req(REQ_ADC, CMD_OFF, '1);
        push_req(REQ_TICK, '0, '0);
        push_req(REQ_TICK, '1, '1);           // max run reached: safety stop
        push_req(REQ_CMD, CMD_ON, '0);        // refused during cooldown
        push_req(REQ_TICK, '0, '0);
        push_req(REQ_TICK, '0, '0);           // cooldown over
        push_req(REQ_CMD, CMD_ON, '0);
        push_req(REQ_CMD, CMD_OFF, '0);
        push_req(REQ_CMD, CMD_ON, '1);
        push_req(REQ_CMD, CMD_MANUAL, '0);    // stop without cooldown
        push_req(REQ_CMD, CMD_STREAM_OFF, '0);
        push_req(REQ_UNUSED, '1, '0);
        push_req(REQ_UNUSED, '0, '1);
        wait_idle();

        for (ph = 0; ph < N_PHASES; ph++) begin
            tick_share  = 35;
            quiet_cmds  = 1'b0;
            phase_items = 113;
            case (ph)
                0: write_all(0, 0, 1, 2, 4095, 0);
                1: begin
                    // longest timers, stop level out of reach: pump runs to the limit
                    write_all(95, 100, 255, 255, 2700, 1500);
                    tick_share  = 85;
                    quiet_cmds  = 1'b1;
                    phase_items = 600;
                end
                2: write_all(RST_DRY_THR, RST_OFF_MARGIN, RST_MAX_RUN, RST_COOL_TICKS,
                             RST_RAW_DRY, RST_RAW_WET);
                // cooldown shorter than its range: safety stop and end on one tick
                3: write_all(50, 10, 5, 1, 3000, 1000);
                4: write_all(60, 3, 0, 0, 3500, 500);
                5: write_all(40, 5, 4, 3, 2000, 2000);   // empty calibration span
                6: write_all(20, 7, 3, 4, 0, 4095);      // inverted calibration
                default: begin
                    n = $urandom_range(0, 3000);
                    write_all($urandom_range(0, 95), $urandom_range(0, 20),
                              $urandom_range(1, 20), $urandom_range(2, 20),
                              n + 1 + $urandom_range(0, 4094 - n), n);
                end
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (n = 0; n < phase_items; n++) begin
                make_req(gen_item);
                req_queue.push_back(gen_item);
            end
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
